// ----- hdl/psbb_pkg.sv -----
// ---------------------------------------------------------------------------
// psbb_pkg: shared types for the per-segment batch buffer
// Request and result beats, controller states, and the command/status
// bundles that pass between controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package psbb_pkg;

	localparam int STORE_W = 2;
	localparam int SEG_W   = 4;
	localparam int VALUE_W = 32;

	// Number of codes the store and segment fields can carry.
	localparam int STORE_SPAN = 1 << STORE_W;
	localparam int SEG_SPAN   = 1 << SEG_W;

	localparam logic REQ_ADD   = 1'b0;
	localparam logic REQ_FLUSH = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic [STORE_W-1:0] store_sel;
		logic [SEG_W-1:0]   segment;
		logic [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [STORE_W-1:0] out_store;
		logic [SEG_W-1:0]   out_segment;
		logic [VALUE_W-1:0] out_value;
		logic               run_last;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_UPDATE,
		ST_DRAIN_RD,
		ST_DRAIN_LD
	} state_t;

	typedef struct packed {
		logic load_req;
		logic cnt_rd;
		logic upd;
		logic drain_rd;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic req_ok;
		logic drain_go;
		logic last_beat;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ----- hdl/psbb_ctrl.sv -----
// ---------------------------------------------------------------------------
// psbb_ctrl: sequencing controller
// Steps one request through count lookup, update and drain.
// ---------------------------------------------------------------------------
`default_nettype none

module psbb_ctrl import psbb_pkg::*; (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  req_valid,
	output logic req_stall,
	input  wire sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_nxt    = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				// drop requests aimed outside the configured stores/segments
				cmd.cnt_rd = 1'b1;
				state_nxt  = sts.req_ok ? ST_UPDATE : ST_IDLE;
			end
			ST_UPDATE: begin
				cmd.upd   = 1'b1;
				state_nxt = sts.drain_go ? ST_DRAIN_RD : ST_IDLE;
			end
			ST_DRAIN_RD: begin
				cmd.drain_rd = 1'b1;
				state_nxt    = ST_DRAIN_LD;
			end
			ST_DRAIN_LD: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = sts.last_beat ? ST_IDLE : ST_DRAIN_RD;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- hdl/psbb_datapath.sv -----
// ---------------------------------------------------------------------------
// psbb_datapath: request register, fill-count and value memories, drain
// Holds the buffered values and fill counts and drives the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module psbb_datapath import psbb_pkg::*; #(
	parameter int NUM_STORES   = 4,
	parameter int NUM_SEGMENTS = 16,
	parameter int RUN_LENGTH   = 16
) (
	input  wire  clk,
	input  wire  arst_n,
	input  wire req_t req_data,
	input  wire cmd_t cmd,
	output sts_t sts,
	output logic rsp_valid,
	input  wire  rsp_stall,
	output rsp_t rsp_data
);

	localparam int EFF_STORES = (NUM_STORES < STORE_SPAN) ? NUM_STORES : STORE_SPAN;
	localparam int EFF_SEGS   = (NUM_SEGMENTS < SEG_SPAN) ? NUM_SEGMENTS : SEG_SPAN;
	localparam int SLOTS      = EFF_STORES * EFF_SEGS;
	localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int HOLD_DEPTH = SLOTS * RUN_LENGTH;
	localparam int HOLD_AW    = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
	localparam int CNT_W      = $clog2(RUN_LENGTH + 1);
	localparam logic [CNT_W-1:0] RUN_LEN_C = CNT_W'(RUN_LENGTH);
	localparam logic [CNT_W-1:0] RUN_TOP_C = CNT_W'(RUN_LENGTH - 1);
	localparam logic [CNT_W-1:0] ONE_C     = CNT_W'(1);

	req_t               req_q;
	logic [CNT_W-1:0]   cnt_mem [SLOTS];
	logic [CNT_W-1:0]   cnt_rd_q;
	logic [SLOTS-1:0]   cnt_vld_q;
	logic [VALUE_W-1:0] hold_mem [HOLD_DEPTH];
	logic [VALUE_W-1:0] hold_rd_q;
	logic [CNT_W-1:0]   k_q;
	logic [CNT_W-1:0]   len_q;
	logic               out_vld_q;
	rsp_t               out_q;

	logic [SLOT_W-1:0]  slot;
	logic               req_ok;
	logic [CNT_W-1:0]   cnt_cur;
	logic [CNT_W-1:0]   add_pos;
	logic [CNT_W-1:0]   add_nxt;
	logic               add_full;
	logic [CNT_W-1:0]   cnt_wr;
	logic [CNT_W-1:0]   drain_len;
	logic [HOLD_AW-1:0] hold_base;
	logic [HOLD_AW-1:0] hold_addr;
	logic               is_add;

	always_comb begin
		req_ok    = (int'(req_q.store_sel) < NUM_STORES) && (int'(req_q.segment) < NUM_SEGMENTS);
		slot      = SLOT_W'(req_q.store_sel * EFF_SEGS + req_q.segment);
		is_add    = (req_q.req_type == REQ_ADD);
		cnt_cur   = cnt_vld_q[slot] ? cnt_rd_q : '0;
		// clamp a full count to the last entry
		add_pos   = (cnt_cur >= RUN_LEN_C) ? RUN_TOP_C : cnt_cur;
		add_nxt   = add_pos + ONE_C;
		add_full  = (add_nxt == RUN_LEN_C);
		if (is_add) begin
			cnt_wr    = add_full ? '0 : add_nxt;
			drain_len = add_full ? RUN_LEN_C : '0;
		end else begin
			cnt_wr    = '0;
			drain_len = (cnt_cur > RUN_LEN_C) ? RUN_LEN_C : cnt_cur;
		end
		hold_base = HOLD_AW'(slot * RUN_LENGTH);
		hold_addr = hold_base + HOLD_AW'(cmd.upd ? add_pos : k_q);
	end

	always_comb begin
		sts.req_ok    = req_ok;
		sts.drain_go  = (drain_len != '0);
		sts.last_beat = (CNT_W'(k_q + ONE_C) == len_q);
		sts.out_free  = !out_vld_q || !rsp_stall;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req_data;
		end
	end

	// fill-count memory: one read, one write port
	always_ff @(posedge clk) begin
		if (cmd.cnt_rd && req_ok) begin
			cnt_rd_q <= cnt_mem[slot];
		end
		if (cmd.upd) begin
			cnt_mem[slot] <= cnt_wr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q <= '0;
		end else if (cmd.upd) begin
			cnt_vld_q[slot] <= 1'b1;
		end
	end

	// value memory: written on add, read during drain
	always_ff @(posedge clk) begin
		if (cmd.upd && is_add) begin
			hold_mem[hold_addr] <= req_q.value;
		end
		if (cmd.drain_rd) begin
			hold_rd_q <= hold_mem[hold_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			k_q   <= '0;
			len_q <= drain_len;
		end else if (cmd.out_load) begin
			k_q <= k_q + ONE_C;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.out_store   <= req_q.store_sel;
			out_q.out_segment <= req_q.segment;
			out_q.out_value   <= hold_rd_q;
			out_q.run_last    <= sts.last_beat;
		end
	end

	assign rsp_valid = out_vld_q;
	assign rsp_data  = out_q;

endmodule

`default_nettype wire

// ----- hdl/per_segment_batch_buffer.sv -----
// ---------------------------------------------------------------------------
// per_segment_batch_buffer: write-combining buffer per store and segment
//
// Request channel (req_valid / req_stall / req_data): each beat either adds
// a 32-bit value to one segment of one store, or flushes that segment.
// Requests naming a store or segment beyond the configured count are dropped.
// Result channel (rsp_valid / rsp_stall / rsp_data): a drained segment
// comes out oldest value first, tagged with its store and segment, with
// run_last set on the final beat of the run.
// An add that fills a segment to RUN_LENGTH drains all of it; a flush
// drains whatever the segment holds, or nothing if it is empty.
// One request is worked on at a time. A request that drains nothing passes
// through accept, count lookup and update, and one that is dropped stops
// after the lookup. Each drain beat is a registered read of the value
// memory and then a load of the result register, and the next value is not
// read until that load. The first beat follows lookup, update and a read.
// A stalled receiver holds the result register and pauses the drain;
// req_stall stays high until the drain is done.
// Reset clears all fill counts (valid bits); unwritten values are never read.
// ---------------------------------------------------------------------------
`default_nettype none

module per_segment_batch_buffer import psbb_pkg::*; #(
	parameter int NUM_STORES   = 4,
	parameter int NUM_SEGMENTS = 16,
	parameter int RUN_LENGTH   = 16
) (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  req_valid,
	output logic req_stall,
	input  wire req_t req_data,
	output logic rsp_valid,
	input  wire  rsp_stall,
	output rsp_t rsp_data
);

	// command and status bundles between controller and datapath
	cmd_t cmd;
	sts_t sts;

	psbb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	psbb_datapath #(
		.NUM_STORES   (NUM_STORES),
		.NUM_SEGMENTS (NUM_SEGMENTS),
		.RUN_LENGTH   (RUN_LENGTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

endmodule

`default_nettype wire
